### design/dq_pkg.sv
// shared types and constants for the double-ended queue core
// no dependencies; used by dq_cell, double_ended_queue_core and dq_checker
package dq_pkg;

   localparam int DEPTH       = 16;
   localparam int WORD_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      FUNC_QUERY      = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_PUSH_FRONT = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_POP_FRONT  = 3'd4,
      FUNC_CLEAR      = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2
   } err_type;

   typedef struct packed {
      logic add_front;
      logic add_back;
      logic take_front;
      logic take_back;
      logic clear;
   } cell_ctl_type;

endpackage

### design/dq_cell.sv
// one storage cell of the queue row: a word and its valid flag
// depends on dq_pkg; trades data with its left and right neighbors
module dq_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  dq_pkg::cell_ctl_type             ctl,
   input  logic [dq_pkg::WORD_WIDTH-1:0]    push_word,
   input  logic [dq_pkg::WORD_WIDTH-1:0]    left_data,
   input  logic                             left_valid,
   input  logic [dq_pkg::WORD_WIDTH-1:0]    right_data,
   input  logic                             right_valid,
   output logic [dq_pkg::WORD_WIDTH-1:0]    data,
   output logic                             valid,
   output logic                             is_tail
);

   logic [dq_pkg::WORD_WIDTH-1:0] data_ff, data_in;
   logic                          valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.add_front) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctl.add_back && !valid_ff && left_valid) begin
         data_in  = push_word;
         valid_in = 1'b1;
      end else if (ctl.take_front) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctl.take_back && valid_ff && !right_valid) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign valid   = valid_ff;
   assign is_tail = valid_ff && !right_valid;

endmodule

### design/double_ended_queue_core.sv
// double-ended queue core: row of dq_cell entries, op decode, count and result register
// latency: result beat valid the cycle after the request beat is accepted
// throughput: one operation per cycle while results are taken; limited by the single result register
// the shift row moves every cell one place per push front or pop front in that same cycle
// reset: synchronous, active high; clears all cell valid flags, the count and the result valid
// depends on dq_pkg and dq_cell
module double_ended_queue_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_func,
   input  logic signed [31:0]                 req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 rsp_front_value,
   output logic signed [31:0]                 rsp_back_value,
   output logic                               rsp_ends_valid,
   output logic [dq_pkg::COUNT_WIDTH-1:0]     rsp_entry_count,
   output logic                               rsp_is_empty,
   output logic [1:0]                         rsp_error_code
);

   localparam int DEPTH = dq_pkg::DEPTH;
   localparam int WW    = dq_pkg::WORD_WIDTH;
   localparam int CW    = dq_pkg::COUNT_WIDTH;

   logic                    accept;
   logic                    full;
   logic                    empty;
   dq_pkg::cell_ctl_type    ctl;
   dq_pkg::err_type         err_in, err_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [63:0]      value_ext;
   logic [WW-1:0]           push_word;
   logic [WW-1:0]           cell_data  [DEPTH];
   logic                    cell_valid [DEPTH];
   logic                    cell_tail  [DEPTH];
   logic [WW-1:0]           back_word;
   logic [63:0]             front_ext;
   logic [63:0]             back_ext;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign full      = cell_valid[DEPTH-1];
   assign empty     = !cell_valid[0];

   assign value_ext = 64'(req_value);
   assign push_word = value_ext[WW-1:0];

   always_comb begin
      ctl      = '0;
      err_in   = dq_pkg::ERR_OK;
      count_in = count_ff;
      unique case (req_func)
         dq_pkg::FUNC_PUSH_BACK: begin
            if (full) begin
               err_in = dq_pkg::ERR_OVERFLOW;
            end else begin
               ctl.add_back = accept;
               count_in     = count_ff + CW'(1);
            end
         end
         dq_pkg::FUNC_PUSH_FRONT: begin
            if (full) begin
               err_in = dq_pkg::ERR_OVERFLOW;
            end else begin
               ctl.add_front = accept;
               count_in      = count_ff + CW'(1);
            end
         end
         dq_pkg::FUNC_POP_BACK: begin
            if (empty) begin
               err_in = dq_pkg::ERR_UNDERFLOW;
            end else begin
               ctl.take_back = accept;
               count_in      = count_ff - CW'(1);
            end
         end
         dq_pkg::FUNC_POP_FRONT: begin
            if (empty) begin
               err_in = dq_pkg::ERR_UNDERFLOW;
            end else begin
               ctl.take_front = accept;
               count_in       = count_ff - CW'(1);
            end
         end
         dq_pkg::FUNC_CLEAR: begin
            ctl.clear = accept;
            count_in  = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [WW-1:0] l_data;
         logic          l_valid;
         logic [WW-1:0] r_data;
         logic          r_valid;
         if (gi == 0) begin : g_first
            assign l_data  = push_word;
            assign l_valid = 1'b1;
         end else begin : g_mid_l
            assign l_data  = cell_data[gi-1];
            assign l_valid = cell_valid[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign r_data  = '0;
            assign r_valid = 1'b0;
         end else begin : g_mid_r
            assign r_data  = cell_data[gi+1];
            assign r_valid = cell_valid[gi+1];
         end
         dq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .push_word   (push_word),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (cell_data[gi]),
            .valid       (cell_valid[gi]),
            .is_tail     (cell_tail[gi])
         );
      end
   endgenerate

   // back word: and-or over the one-hot tail flags
   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | (cell_data[i] & {WW{cell_tail[i]}});
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         err_ff       <= dq_pkg::ERR_OK;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
            err_ff   <= err_in;
         end
      end
   end

   // end values and flags read straight from the cells; they hold until the next accepted beat
   assign front_ext = 64'(cell_data[0] & {WW{cell_valid[0]}});
   assign back_ext  = 64'(back_word);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = front_ext[31:0];
   assign rsp_back_value  = back_ext[31:0];
   assign rsp_ends_valid  = cell_valid[0];
   assign rsp_entry_count = count_ff;
   assign rsp_is_empty    = !cell_valid[0];
   assign rsp_error_code  = err_ff;

endmodule

### design/dq_checker.sv
// port-level checker for double_ended_queue_core, attached by bind
// depends on dq_pkg and the top-level ports only
module dq_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [31:0]                 rsp_front_value,
   input  logic signed [31:0]                 rsp_back_value,
   input  logic                               rsp_ends_valid,
   input  logic [dq_pkg::COUNT_WIDTH-1:0]     rsp_entry_count,
   input  logic                               rsp_is_empty,
   input  logic [1:0]                         rsp_error_code
);

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   a_ends_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ends_valid == !rsp_is_empty))
      else $error("ends valid disagrees with empty flag");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_front_value == 0 && rsp_back_value == 0))
      else $error("end values not zero on empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= dq_pkg::COUNT_WIDTH'(dq_pkg::DEPTH)))
      else $error("entry count above depth");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_entry_count)
         && $stable(rsp_error_code)))
      else $error("stalled result beat changed");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_front_value (rsp_front_value),
   .rsp_back_value  (rsp_back_value),
   .rsp_ends_valid  (rsp_ends_valid),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_error_code  (rsp_error_code)
);
